@@ sv/gost_pkg.sv @@
// Shared types, constants, S-box table and round helpers for the GOST cipher block.
package gost_pkg;

    localparam int RoundCount = 32;
    localparam int KeyWords   = 8;
    localparam int KeyIdxW    = 3;
    localparam int RoundIdxW  = 5;
    localparam int WordW      = 32;
    localparam int NibbleW    = 4;
    localparam int Nibbles    = WordW / NibbleW;
    localparam int RotBits    = 11;
    localparam int LateRound  = 24;

    localparam logic [RoundIdxW-1:0] RevMask = 5'h1F;

    typedef logic [WordW-1:0]   word_t;
    typedef logic [KeyIdxW-1:0] key_idx_t;

    typedef struct packed {
        word_t left;
        word_t right;
        logic  decrypt;
    } gost_beat_t;

    localparam logic [NibbleW-1:0] SBOX [0:Nibbles-1][0:15] = '{
        '{4'h9, 4'h6, 4'h3, 4'h2, 4'h8, 4'hB, 4'h1, 4'h7,
          4'hA, 4'h4, 4'hE, 4'hF, 4'hC, 4'h0, 4'hD, 4'h5},
        '{4'h3, 4'h7, 4'hE, 4'h9, 4'h8, 4'hA, 4'hF, 4'h0,
          4'h5, 4'h2, 4'h6, 4'hC, 4'hB, 4'h4, 4'hD, 4'h1},
        '{4'hE, 4'h4, 4'h6, 4'h2, 4'hB, 4'h3, 4'hD, 4'h8,
          4'hC, 4'hF, 4'h5, 4'hA, 4'h0, 4'h7, 4'h1, 4'h9},
        '{4'hE, 4'h7, 4'hA, 4'hC, 4'hD, 4'h1, 4'h3, 4'h9,
          4'h0, 4'h2, 4'hB, 4'h4, 4'hF, 4'h8, 4'h5, 4'h6},
        '{4'hB, 4'h5, 4'h1, 4'h9, 4'h8, 4'hD, 4'hF, 4'h0,
          4'hE, 4'h4, 4'h2, 4'h3, 4'hC, 4'h7, 4'hA, 4'h6},
        '{4'h3, 4'hA, 4'hD, 4'hC, 4'h1, 4'h2, 4'h0, 4'hB,
          4'h7, 4'h5, 4'h9, 4'h4, 4'h8, 4'hF, 4'hE, 4'h6},
        '{4'h1, 4'hD, 4'h2, 4'h9, 4'h7, 4'hA, 4'h6, 4'h0,
          4'h8, 4'hC, 4'h4, 4'h5, 4'hF, 4'h3, 4'hB, 4'hE},
        '{4'hB, 4'hA, 4'hF, 4'h5, 4'h0, 4'hC, 4'hE, 4'h8,
          4'h6, 4'h2, 4'h3, 4'h9, 4'h1, 4'h7, 4'hD, 4'h4}
    };

    function automatic word_t gost_round_fn(word_t half, word_t rk);
        word_t s;
        word_t t;
        s = half + rk;
        t = '0;
        for (int i = 0; i < Nibbles; i++)
        begin
            t[NibbleW*i +: NibbleW] = SBOX[i][s[NibbleW*i +: NibbleW]];
        end
        return {t[WordW-1-RotBits:0], t[WordW-1:WordW-RotBits]};
    endfunction

    function automatic key_idx_t gost_key_index(logic [RoundIdxW-1:0] r);
        key_idx_t k;
        if (r < RoundIdxW'(LateRound))
            k = r[KeyIdxW-1:0];
        else
            k = ~r[KeyIdxW-1:0];
        return k;
    endfunction

endpackage

@@ sv/gost_round_cell.sv @@
// One Feistel round of the cipher pipeline with its stage register.
module gost_round_cell
    import gost_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic       prev_valid,
    input  gost_beat_t prev_beat,
    input  word_t      key_enc,
    input  word_t      key_dec,
    output logic       valid,
    output gost_beat_t beat
);

    logic       valid_reg;
    logic       valid_next;
    gost_beat_t beat_reg;
    gost_beat_t beat_next;
    word_t      rk;

    always_comb
    begin
        rk                 = prev_beat.decrypt ? key_dec : key_enc;
        beat_next.left     = prev_beat.right;
        beat_next.right    = prev_beat.left ^ gost_round_fn(prev_beat.right, rk);
        beat_next.decrypt  = prev_beat.decrypt;
        valid_next         = prev_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            beat_reg <= beat_next;
    end

    assign valid = valid_reg;
    assign beat  = beat_reg;

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        rst_n && !advance && valid_reg |=> valid_reg && $stable(beat_reg))
        else $error("round cell lost or changed a held beat");

    a_valid_follows: assert property (@(posedge clk) disable iff (!rst_n)
        rst_n && advance |=> valid_reg == $past(prev_valid))
        else $error("round cell valid did not follow its neighbor");

    a_swap_halves: assert property (@(posedge clk) disable iff (!rst_n)
        rst_n && advance && prev_valid |=> beat_reg.left == $past(prev_beat.right)
            && beat_reg.decrypt == $past(prev_beat.decrypt))
        else $error("round cell did not pass the right half on");

endmodule

@@ sv/gost_block_cipher_ecb.sv @@
// Top level of the GOST 28147-89 ECB cipher: key registers and a chain of 32 round cells.
//
// Input channel: in_valid / in_stall with data_block (left half in bits 63..32) and
// decrypt. A beat is taken at a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with result_block (final right half upper).
// Key port: cfg_valid / cfg_ready with cfg_index (key word 0..7) and cfg_data;
// cfg_ready is always high. Write keys only while no block is in flight.
// Each round cell registers its beat; a block passes the 32 cell registers in order.
// Throughput: one block per cycle while out_stall holds no waiting result, set by
// the chain of 32 single-round cells that all advance together.
// Reset clears the key words to zero and empties the chain; blocks in flight drop.
// When out_stall holds a waiting result, the whole chain freezes and in_stall
// rises in the same cycle; blocks in flight keep their place until it drops.
module gost_block_cipher_ecb
    import gost_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [63:0]          data_block,
    input  logic                 decrypt,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [63:0]          result_block,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [KeyIdxW-1:0]   cfg_index,
    input  logic [WordW-1:0]     cfg_data
);

    word_t      key_words_reg [KeyWords];
    logic       stage_valid   [0:RoundCount];
    gost_beat_t stage_beat    [0:RoundCount];
    logic       advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < KeyWords; k++)
            begin
                key_words_reg[k] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            key_words_reg[cfg_index] <= cfg_data;
        end
    end

    assign advance  = !(stage_valid[RoundCount] && out_stall);
    assign in_stall = !advance;

    assign stage_valid[0]        = in_valid;
    assign stage_beat[0].left    = data_block[63:32];
    assign stage_beat[0].right   = data_block[31:0];
    assign stage_beat[0].decrypt = decrypt;

    for (genvar i = 0; i < RoundCount; i++)
    begin : g_round
        gost_round_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .prev_valid (stage_valid[i]),
            .prev_beat  (stage_beat[i]),
            .key_enc    (key_words_reg[gost_key_index(RoundIdxW'(i))]),
            .key_dec    (key_words_reg[gost_key_index(RoundIdxW'(i) ^ RevMask)]),
            .valid      (stage_valid[i+1]),
            .beat       (stage_beat[i+1])
        );
    end

    assign out_valid    = stage_valid[RoundCount];
    assign result_block = {stage_beat[RoundCount].right, stage_beat[RoundCount].left};

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a waiting result");

    a_key_written: assert property (@(posedge clk) disable iff (!rst_n)
        rst_n && cfg_valid && cfg_ready && cfg_index == KeyIdxW'(0)
            |=> key_words_reg[0] == $past(cfg_data))
        else $error("key word zero not written");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        rst_n && out_valid && out_stall |=> out_valid && $stable(result_block))
        else $error("stalled result changed");

endmodule
